// ===== rtl/mcrs_pkg.sv =====
package mcrs_pkg;

  localparam int SLOTS      = 16;
  localparam int CONSUMERS  = 8;
  localparam int DATA_WIDTH = 32;
  localparam int POS_W      = $clog2(SLOTS);
  localparam int CONS_W     = 3;
  localparam int CNT_W      = 4;
  localparam int DEP_STRIDE = 8;
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 2;

  localparam logic [1:0] KIND_PROVIDE = 2'd0;
  localparam logic [1:0] KIND_QUERY   = 2'd1;
  localparam logic [1:0] KIND_FINISH  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_RUNNING    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEP_MATRIX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE     = 2'd2;

  typedef struct packed {
    logic [1:0]            kind;
    logic [CONS_W-1:0]     consumer_index;
    logic [DATA_WIDTH-1:0] data_value;
  } in_item_t;

  typedef struct packed {
    logic                  accepted;
    logic                  available;
    logic [POS_W-1:0]      slot_index;
    logic [DATA_WIDTH-1:0] slot_value;
    logic                  ring_empty;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOVE,
    ST_EXEC,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic load;
    logic move_tail;
    logic rd_en;
    logic exec;
  } dp_cmd_t;

  typedef struct packed {
    logic is_provide;
  } dp_status_t;

  function automatic logic [POS_W-1:0] wrap_inc(input logic [POS_W-1:0] p);
    logic [POS_W-1:0] r;
    if (p == POS_W'(SLOTS - 1)) begin
      r = '0;
    end else begin
      r = p + POS_W'(1);
    end
    return r;
  endfunction

endpackage

// ===== rtl/multi_consumer_ring_sequencer_top.sv =====
// Ring of sixteen 32-bit slots with one producer and up to eight consumers
// whose ordering follows a dependency matrix. Each request is a provide, a
// query or a finish, and gives exactly one result. Requests are handled one
// at a time: a request is taken in the idle state, the tail catch-up and the
// registered slot read happen in the next cycle and the update in the one
// after; the result is then offered and held until out_ready takes it, and
// only then can a new request be taken. A result that waits for out_ready
// holds off the next request for as long as it waits.
// Configuration writes are applied at once and should only be made while no
// request is in flight.
module multi_consumer_ring_sequencer_top
  import mcrs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  dp_cmd_t    cmd;
  dp_status_t status;

  mcrs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  mcrs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// ===== rtl/mcrs_ctrl.sv =====
module mcrs_ctrl
  import mcrs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MOVE;
        end
      end
      ST_MOVE: begin
        // The tail only catches up with the consumers ahead of a provide.
        cmd.move_tail = status.is_provide;
        cmd.rd_en     = 1'b1;
        state_nxt     = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/mcrs_dp.sv =====
module mcrs_dp
  import mcrs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  in_item_t             in_data,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  dp_cmd_t              cmd,
  output dp_status_t           status
);

  in_item_t              item_r;
  logic                  running_r;
  logic [CFG_W-1:0]      dep_r;
  logic [CNT_W-1:0]      active_r;
  logic [POS_W-1:0]      head_r;
  logic [POS_W-1:0]      tail_r;
  logic [POS_W-1:0]      pos_r [CONSUMERS];
  logic [DATA_WIDTH-1:0] rd_data_r;
  out_item_t             out_r;
  out_item_t             out_nxt;
  logic [DATA_WIDTH-1:0] mem [SLOTS];

  logic [CNT_W-1:0]      live_cnt;
  logic [CONSUMERS-1:0]  live;
  logic [CONS_W-1:0]     who;
  logic [POS_W-1:0]      step;
  logic [POS_W:0]        gap;
  logic [POS_W:0]        tail_sum;
  logic [POS_W-1:0]      tail_moved;
  logic [POS_W-1:0]      slot;
  logic [DEP_STRIDE-1:0] dep_row;
  logic                  slot_ok;
  logic                  prov_ok;
  logic [POS_W-1:0]      head_exec;
  logic                  do_write;

  assign who               = item_r.consumer_index;
  assign status.is_provide = (item_r.kind == KIND_PROVIDE);
  assign out_data          = out_r;

  // An active count of zero behaves as one, and counts above the ring's
  // consumer capacity are clipped.
  always_comb begin
    if (active_r == '0) begin
      live_cnt = CNT_W'(1);
    end else if (active_r > CNT_W'(CONSUMERS)) begin
      live_cnt = CNT_W'(CONSUMERS);
    end else begin
      live_cnt = active_r;
    end
    for (int c = 0; c < CONSUMERS; c++) begin
      live[c] = (CNT_W'(c) < live_cnt);
    end
  end

  // Nearest live consumer ahead of the tail, measured round the ring.
  always_comb begin
    step = POS_W'(SLOTS - 1);
    gap  = '0;
    for (int c = 0; c < CONSUMERS; c++) begin
      if (pos_r[c] >= tail_r) begin
        gap = {1'b0, pos_r[c]} - {1'b0, tail_r};
      end else begin
        gap = {1'b0, pos_r[c]} + (POS_W+1)'(SLOTS) - {1'b0, tail_r};
      end
      if (live[c] && (gap[POS_W-1:0] < step)) begin
        step = gap[POS_W-1:0];
      end
    end
    tail_sum = {1'b0, tail_r} + {1'b0, step};
    if (tail_sum >= (POS_W+1)'(SLOTS)) begin
      tail_sum = tail_sum - (POS_W+1)'(SLOTS);
    end
    if (tail_r == head_r) begin
      tail_moved = tail_r;
    end else begin
      tail_moved = tail_sum[POS_W-1:0];
    end
  end

  // A slot is ready when the producer has moved past it and no consumer
  // that this one waits on is still working on it.
  always_comb begin
    slot    = pos_r[who];
    dep_row = dep_r[int'(who) * DEP_STRIDE +: DEP_STRIDE];
    slot_ok = (slot != head_r);
    for (int i = 0; i < CONSUMERS; i++) begin
      if (live[i] && dep_row[i] && (pos_r[i] == slot)) begin
        slot_ok = 1'b0;
      end
    end
  end

  assign prov_ok   = running_r && (wrap_inc(head_r) != tail_r);
  assign do_write  = cmd.exec && status.is_provide && prov_ok;
  assign head_exec = do_write ? wrap_inc(head_r) : head_r;

  always_comb begin
    out_nxt            = '0;
    out_nxt.ring_empty = (head_exec == tail_r);
    case (item_r.kind)
      KIND_PROVIDE: begin
        out_nxt.accepted = prov_ok;
      end
      KIND_QUERY: begin
        if (live[who]) begin
          out_nxt.slot_index = slot;
          out_nxt.available  = slot_ok;
          if (slot_ok) begin
            out_nxt.slot_value = rd_data_r;
          end
        end
      end
      default: begin
        out_nxt.accepted = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      dep_r     <= '0;
      active_r  <= CNT_W'(1);
      head_r    <= '0;
      tail_r    <= '0;
      for (int c = 0; c < CONSUMERS; c++) begin
        pos_r[c] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_RUNNING:    running_r <= cfg_wdata[0];
          REG_DEP_MATRIX: dep_r     <= cfg_wdata;
          REG_ACTIVE:     active_r  <= cfg_wdata[CNT_W-1:0];
          default: begin
            running_r <= running_r;
          end
        endcase
      end
      if (cmd.move_tail) begin
        tail_r <= tail_moved;
      end
      if (cmd.exec) begin
        head_r <= head_exec;
        if ((item_r.kind == KIND_FINISH) && live[who]) begin
          pos_r[who] <= wrap_inc(pos_r[who]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (cmd.exec) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[head_r] <= item_r.data_value;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[pos_r[who]];
    end
  end

endmodule

// ===== test/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mcrs_pkg::*;

  localparam logic [1:0] KIND_UNKNOWN = 2'd3;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int PRINT_LIMIT = 100;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  multi_consumer_ring_sequencer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Shadow copy of the ring, the consumer positions and the registers.
  logic [POS_W-1:0]      head_pos = '0;
  logic [POS_W-1:0]      tail_pos = '0;
  logic [POS_W-1:0]      cons_pos [CONSUMERS];
  logic [DATA_WIDTH-1:0] ring_store [SLOTS];
  bit                    slot_written [SLOTS];
  logic                  cfg_running = 1'b0;
  logic [CFG_W-1:0]      dep_matrix = '0;
  logic [CNT_W-1:0]      active_setting = CNT_W'(1);

  in_item_t  pending_requests[$];
  out_item_t expected_results[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_requested = 1'b0;
  logic receiver_held = 1'b0;

  int error_count = 0;
  int requests_taken = 0;
  int results_checked = 0;
  int provides_stored = 0;
  int provides_refused = 0;
  int queries_ready = 0;
  int settings_used = 0;

  initial begin
    for (int i = 0; i < CONSUMERS; i++) cons_pos[i] = '0;
    for (int i = 0; i < SLOTS; i++) begin
      ring_store[i] = '0;
      slot_written[i] = 1'b0;
    end
  end

  function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] p);
    return POS_W'((p + 1) % SLOTS);
  endfunction

  function automatic int unsigned live_consumers();
    int unsigned n;
    n = active_setting;
    if (n < 1) n = 1;
    if (n > CONSUMERS) n = CONSUMERS;
    return n;
  endfunction

  // A consumer may take its slot once the producer has moved past it and no
  // consumer it waits on is still sitting there.
  function automatic bit slot_ready(input int unsigned c);
    bit ok;
    ok = cons_pos[c] != head_pos;
    for (int unsigned i = 0; i < live_consumers(); i++) begin
      if (dep_matrix[c * DEP_STRIDE + i] && cons_pos[i] == cons_pos[c]) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic out_item_t sequence_request(input in_item_t req);
    out_item_t    res;
    int unsigned  n;
    int unsigned  step;
    int unsigned  gap;
    bit           live;
    res = '0;
    n = live_consumers();
    live = req.consumer_index < n;
    case (req.kind)
      KIND_PROVIDE: begin
        if (tail_pos != head_pos) begin
          step = SLOTS - 1;
          for (int unsigned c = 0; c < n; c++) begin
            gap = (cons_pos[c] + SLOTS - tail_pos) % SLOTS;
            if (gap < step) step = gap;
          end
          tail_pos = POS_W'((tail_pos + step) % SLOTS);
        end
        if (cfg_running && next_pos(head_pos) != tail_pos) begin
          ring_store[head_pos] = req.data_value;
          slot_written[head_pos] = 1'b1;
          head_pos = next_pos(head_pos);
          res.accepted = 1'b1;
          provides_stored++;
        end else begin
          provides_refused++;
        end
      end
      KIND_QUERY: begin
        if (live) begin
          res.slot_index = cons_pos[req.consumer_index];
          if (slot_ready(req.consumer_index)) begin
            res.available = 1'b1;
            res.slot_value = ring_store[cons_pos[req.consumer_index]];
            queries_ready++;
          end
        end
      end
      KIND_FINISH: begin
        if (live) cons_pos[req.consumer_index] = next_pos(cons_pos[req.consumer_index]);
      end
      default: begin
      end
    endcase
    res.ring_empty = head_pos == tail_pos;
    return res;
  endfunction

  function automatic in_item_t make_request(input logic [1:0] kind, input int who,
                                            input logic [DATA_WIDTH-1:0] value);
    in_item_t req;
    req.kind = kind;
    req.consumer_index = CONS_W'(who);
    req.data_value = value;
    return req;
  endfunction

  // Mostly well-formed traffic: finishes and queries lean towards consumers
  // whose slot is ready, with some unchecked finishes and stray indices.
  function automatic in_item_t random_request();
    in_item_t    req;
    int unsigned n;
    int unsigned roll;
    int          ready_list[$];
    n = live_consumers();
    roll = $urandom_range(0, 99);
    req.data_value = $urandom();
    if ($urandom_range(0, 9) == 0) begin
      req.consumer_index = CONS_W'($urandom_range(0, CONSUMERS - 1));
    end else begin
      req.consumer_index = CONS_W'($urandom_range(0, n - 1));
    end
    for (int unsigned c = 0; c < n; c++) begin
      if (slot_ready(c)) ready_list.push_back(c);
    end
    if (roll < 3) begin
      req.kind = KIND_UNKNOWN;
    end else if (roll < 40) begin
      req.kind = KIND_PROVIDE;
    end else begin
      req.kind = (roll < 70) ? KIND_QUERY : KIND_FINISH;
      if (ready_list.size() != 0 && $urandom_range(0, 99) < 80) begin
        req.consumer_index = CONS_W'(ready_list[$urandom_range(0, ready_list.size() - 1)]);
      end
    end
    // A consumer that has run past the head may sit on a slot never filled;
    // its data must not be read, so such a query becomes a provide.
    if (req.kind == KIND_QUERY && req.consumer_index < n && slot_ready(req.consumer_index) &&
        !slot_written[cons_pos[req.consumer_index]]) begin
      req.kind = KIND_PROVIDE;
    end
    return req;
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < PRINT_LIMIT) $display("MISMATCH at %0t ns: %s", $realtime, msg);
    error_count++;
  endtask

  always @(posedge clk) begin : drive_requests
    logic offer;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(sequence_request(pending_requests.pop_front()));
        requests_taken++;
      end
      if (in_valid && !in_ready) begin
        offer = 1'b1;
      end else begin
        offer = pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct;
      end
      in_valid <= offer;
      if (offer) in_data <= pending_requests[0];
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result arrived with no request outstanding");
        end else begin
          want = expected_results.pop_front();
          if (out_data.accepted !== want.accepted)
            report_mismatch($sformatf("result %0d accepted %b, expected %b",
                                      results_checked, out_data.accepted, want.accepted));
          if (out_data.available !== want.available)
            report_mismatch($sformatf("result %0d available %b, expected %b",
                                      results_checked, out_data.available, want.available));
          if (out_data.slot_index !== want.slot_index)
            report_mismatch($sformatf("result %0d slot_index %0d, expected %0d",
                                      results_checked, out_data.slot_index, want.slot_index));
          if (out_data.slot_value !== want.slot_value)
            report_mismatch($sformatf("result %0d slot_value %h, expected %h",
                                      results_checked, out_data.slot_value, want.slot_value));
          if (out_data.ring_empty !== want.ring_empty)
            report_mismatch($sformatf("result %0d ring_empty %b, expected %b",
                                      results_checked, out_data.ring_empty, want.ring_empty));
          results_checked++;
        end
      end
      out_ready <= !receiver_held && $urandom_range(0, 99) >= recv_stall_pct;
    end
  end

  // Long receiver hold-off so that requests back up behind a parked result.
  initial begin : receiver_hold
    wait (hold_requested);
    @(posedge clk);
    receiver_held <= 1'b1;
    repeat (LONG_HOLD_CYCLES) @(posedge clk);
    receiver_held <= 1'b0;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Timed out with %0d results still outstanding.", expected_results.size());
    $display("multi_consumer_ring_sequencer_top regression: fail");
    $finish;
  end

  task automatic await_turn();
    @(negedge clk);
    while (pending_requests.size() != 0) @(negedge clk);
  endtask

  task automatic send(input logic [1:0] kind, input int who, input logic [DATA_WIDTH-1:0] value);
    await_turn();
    pending_requests.push_back(make_request(kind, who, value));
  endtask

  task automatic drain();
    while (pending_requests.size() != 0 || expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_RUNNING:    cfg_running = value[0];
      REG_DEP_MATRIX: dep_matrix = value;
      REG_ACTIVE:     active_setting = value[CNT_W-1:0];
      default: begin
      end
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_settings(input bit run, input logic [CFG_W-1:0] deps,
                                input logic [CNT_W-1:0] count);
    write_register(REG_RUNNING, CFG_W'(run));
    write_register(REG_DEP_MATRIX, deps);
    write_register(REG_ACTIVE, CFG_W'(count));
    settings_used++;
  endtask

  initial begin : stimulus
    int              item_count;
    bit              run;
    logic [CFG_W-1:0] deps;
    logic [CNT_W-1:0] count;
    bit              drain_pauses;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Paused after reset: a provide is refused and the ring stays empty.
    send(KIND_PROVIDE, 7, '0);
    send(KIND_QUERY, 0, '0);
    send(KIND_UNKNOWN, 7, '1);
    drain();
    // Consumer 2 waits on itself, consumer 3 waits on consumer 7; a count of
    // fifteen is clipped to eight.
    apply_settings(1'b1, 64'h0000_0000_8004_0000, 4'd15);
    send(KIND_PROVIDE, 0, '1);
    send(KIND_PROVIDE, 0, '0);
    send(KIND_QUERY, 2, '0);
    send(KIND_QUERY, 3, '0);
    send(KIND_QUERY, 1, '0);
    send(KIND_FINISH, 7, '0);
    send(KIND_QUERY, 3, '0);
    send(KIND_FINISH, 5, '0);
    send(KIND_FINISH, 5, '0);
    send(KIND_QUERY, 5, '0);
    drain();
    // A count of zero behaves as one, so consumer 5 drops out.
    write_register(REG_ACTIVE, '0);
    send(KIND_QUERY, 5, '0);
    send(KIND_FINISH, 5, '0);
    send(KIND_QUERY, 0, '0);
    send(KIND_FINISH, 0, '0);
    send(KIND_FINISH, 0, '0);
    // Finishing past the head drags the tail along and makes the ring full.
    send(KIND_FINISH, 0, '0);
    send(KIND_PROVIDE, 0, 32'hA5A5_A5A5);
    send(KIND_FINISH, 0, '0);
    send(KIND_PROVIDE, 0, 32'h5A5A_5A5A);

    for (int p = 0; p < 8; p++) begin
      drain();
      item_count = 127;
      run = 1'b1;
      drain_pauses = 1'b0;
      case (p)
        0: begin
          deps = '0;
          count = 4'd1;
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          deps = 64'h4020_1008_0402_0100;
          count = 4'd8;
          send_idle_pct = 84;
          recv_stall_pct = 0;
        end
        2: begin
          deps = {$urandom(), $urandom()};
          count = 4'd4;
          send_idle_pct = 0;
          recv_stall_pct = 84;
        end
        3: begin
          run = 1'b0;
          item_count = 40;
          deps = {$urandom(), $urandom()};
          count = 4'd8;
          send_idle_pct = 10;
          recv_stall_pct = 10;
        end
        4: begin
          deps = '1;
          count = 4'd15;
          send_idle_pct = 0;
          recv_stall_pct = 0;
          hold_requested = 1'b1;
        end
        5: begin
          deps = {$urandom() & $urandom(), $urandom() & $urandom()};
          count = 4'd0;
          send_idle_pct = 84;
          recv_stall_pct = 0;
          drain_pauses = 1'b1;
        end
        6: begin
          deps = {$urandom() & $urandom(), $urandom() & $urandom()};
          count = 4'd6;
          send_idle_pct = 0;
          recv_stall_pct = 84;
        end
        default: begin
          deps = 64'h4020_1008_0402_0100;
          count = 4'd8;
          send_idle_pct = 10;
          recv_stall_pct = 10;
        end
      endcase
      apply_settings(run, deps, count);
      for (int i = 0; i < item_count; i++) begin
        // Now and then the producer waits for every result before going on.
        if (drain_pauses && i % 10 == 9) drain();
        await_turn();
        pending_requests.push_back(random_request());
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("Ran %0d requests under %0d register settings: %0d provides stored, %0d refused.",
             requests_taken, settings_used, provides_stored, provides_refused);
    $display("%0d queries found their slot ready; %0d results checked, %0d mismatches.",
             queries_ready, results_checked, error_count);
    if (error_count == 0) begin
      $display("multi_consumer_ring_sequencer_top regression: pass");
    end else begin
      $display("multi_consumer_ring_sequencer_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/mcrs_pkg.sv
rtl/mcrs_ctrl.sv
rtl/mcrs_dp.sv
rtl/multi_consumer_ring_sequencer_top.sv
test/testbench.sv
